### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the tone sequencer, used by its top level.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: same-cycle implication");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/lts_pkg.sv
// Package for the looping tone sequencer: widths, codes, word and
// control structs. No dependencies.
package lts_pkg;

   localparam int MAX_NOTES      = 16;
   localparam int MAX_PLAY_TICKS = 600000;

   localparam int IDX_W   = $clog2(MAX_NOTES);
   localparam int CNT_W   = $clog2(MAX_NOTES + 1);
   localparam int TICK_W  = 20;
   localparam int PITCH_W = 16;
   localparam int LEN_W   = 16;
   localparam int KIND_W  = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_DURATION = 1'd1;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [3:0]         note_index;
      logic [PITCH_W-1:0] note_pitch;
      logic [LEN_W-1:0]   note_length;
   } req_word_type;

   typedef struct packed {
      logic               tone_on;
      logic [PITCH_W-1:0] tone_pitch;
      logic               is_playing;
      logic               status;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic step;
      logic commit;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_walk;
      logic walk_done;
   } stat_type;

endpackage

### hw/rtl/lts_datapath.sv
// Datapath of the tone sequencer: note tables, counters, config registers,
// note walk accumulator and the result word register. Uses lts_pkg.
module lts_datapath import lts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  req_word_type          req_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output stat_type              stat,
   output rsp_word_type          rsp_word
);

   logic [KIND_W-1:0]  kind_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [PITCH_W-1:0] ld_pitch_ff;
   logic [LEN_W-1:0]   ld_len_ff;

   logic [PITCH_W-1:0] pitch_mem [MAX_NOTES];
   logic [LEN_W-1:0]   len_mem   [MAX_NOTES];

   logic [CNT_W-1:0]   note_count_ff;
   logic [TICK_W-1:0]  play_dur_ff;
   logic [CNT_W-1:0]   active_count_ff;
   logic [TICK_W-1:0]  active_dur_ff;
   logic [TICK_W-1:0]  loop_len_ff;
   logic [TICK_W-1:0]  pos_ff;
   logic [TICK_W-1:0]  elapsed_ff;
   logic               running_ff;
   logic               sounding_ff;
   logic [PITCH_W-1:0] cur_pitch_ff;
   logic               status_ff;

   logic [CNT_W-1:0]   walk_idx_ff;
   logic [TICK_W-1:0]  acc_ff;
   logic               found_ff;
   rsp_word_type       rsp_word_ff;

   logic               start_ok;
   logic [CNT_W-1:0]   count_sat;
   logic [IDX_W-1:0]   entry;
   logic [PITCH_W-1:0] entry_pitch;
   logic [TICK_W:0]    sum_wide;
   logic [TICK_W-1:0]  acc_in;
   logic               hit;
   logic [TICK_W-1:0]  pos_inc;
   logic [TICK_W-1:0]  pos_in;
   logic [TICK_W-1:0]  elapsed_in;

   assign start_ok  = !running_ff && (play_dur_ff <= TICK_W'(MAX_PLAY_TICKS));
   assign count_sat = (note_count_ff > CNT_W'(MAX_NOTES)) ? CNT_W'(MAX_NOTES)
                                                          : note_count_ff;

   assign entry       = walk_idx_ff[IDX_W-1:0];
   assign entry_pitch = pitch_mem[entry];
   assign sum_wide    = {1'b0, acc_ff} + (TICK_W+1)'(len_mem[entry]);
   assign acc_in      = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
   assign hit         = (kind_ff == KIND_TICK) && (pos_ff <= acc_in);

   assign pos_inc    = pos_ff + 1'b1;
   assign pos_in     = (pos_inc >= loop_len_ff) ? '0 : pos_inc;
   assign elapsed_in = elapsed_ff + 1'b1;

   assign stat.need_walk = ((kind_ff == KIND_TICK) && running_ff) ||
                           ((kind_ff == KIND_START) && start_ok);
   assign stat.walk_done = (walk_idx_ff >= active_count_ff) || found_ff;

   // captured item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_word.kind;
         slot_ff     <= req_word.note_index[IDX_W-1:0];
         ld_pitch_ff <= req_word.note_pitch;
         ld_len_ff   <= req_word.note_length;
      end
   end

   // note tables, undefined until loaded
   always_ff @(posedge clock) begin
      if (cmd.exec && (kind_ff == KIND_LOAD)) begin
         pitch_mem[slot_ff] <= ld_pitch_ff;
         len_mem[slot_ff]   <= ld_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_count_ff <= '0;
         play_dur_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NOTE_COUNT:    note_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_PLAY_DURATION: play_dur_ff   <= csr_wdata[TICK_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= '0;
         active_dur_ff   <= '0;
         loop_len_ff     <= '0;
         pos_ff          <= '0;
         elapsed_ff      <= '0;
         running_ff      <= 1'b0;
         sounding_ff     <= 1'b0;
         cur_pitch_ff    <= '0;
         status_ff       <= 1'b0;
         walk_idx_ff     <= '0;
         acc_ff          <= '0;
         found_ff        <= 1'b0;
      end else begin
         if (cmd.exec) begin
            walk_idx_ff <= '0;
            acc_ff      <= '0;
            found_ff    <= 1'b0;
            status_ff   <= (kind_ff == KIND_START) && !start_ok;
            if ((kind_ff == KIND_START) && start_ok) begin
               active_count_ff <= count_sat;
               active_dur_ff   <= play_dur_ff;
            end
            if ((kind_ff == KIND_STOP) && running_ff) begin
               running_ff  <= 1'b0;
               sounding_ff <= 1'b0;
            end
         end
         if (cmd.step) begin
            acc_ff      <= acc_in;
            walk_idx_ff <= walk_idx_ff + 1'b1;
            if (hit) begin
               // first note whose running end reaches the loop position
               found_ff    <= 1'b1;
               sounding_ff <= (entry_pitch != '0);
               if (entry_pitch != '0) begin
                  cur_pitch_ff <= entry_pitch;
               end
            end
         end
         if (cmd.commit) begin
            if (kind_ff == KIND_START) begin
               loop_len_ff <= acc_ff;
               pos_ff      <= '0;
               elapsed_ff  <= '0;
               running_ff  <= 1'b1;
            end else begin
               pos_ff     <= pos_in;
               elapsed_ff <= elapsed_in;
               if (elapsed_in >= active_dur_ff) begin
                  running_ff  <= 1'b0;
                  sounding_ff <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_word_ff.tone_on    <= sounding_ff;
         rsp_word_ff.tone_pitch <= sounding_ff ? cur_pitch_ff : '0;
         rsp_word_ff.is_playing <= running_ff;
         rsp_word_ff.status     <= status_ff;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

### hw/rtl/lts_ctrl.sv
// Controller of the tone sequencer: sequences capture, execute, note walk,
// commit and result handoff; owns the result valid. Uses lts_pkg.
module lts_ctrl import lts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_COMMIT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_walk ? S_WALK : S_FINISH;
         end
         S_WALK: begin
            if (stat.walk_done) begin
               state_in = S_COMMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### hw/rtl/looping_tone_sequencer_top.sv
// Looping tone sequencer: a note table played as a repeating melody.
// Input channel (req_): one word per item: tick, load note, start or stop.
// Result channel (rsp_): exactly one word per item, in item order, with the
// tone state, play state and a reject flag for a start that is refused.
// Config port (csr_): note_count at index 0, play_duration at index 1;
// written only while idle: a rule for the user that the block does not
// enforce. Values are picked up by the next accepted start.
// A load, stop, idle tick or refused start goes through execute and
// finish; an accepted start or a playing tick also walks the note table
// one note per cycle and then commits before it finishes.
// One item is in work at a time; req_stall is high from accept until its
// word enters the output register. The next item is taken while that word
// still waits on rsp_stall; its own result then waits for the slot.
// Reset (synchronous, active high) stops playback, silences the tone and
// clears the counters, config and state registers; the note table holds
// no reset value and a slot must be loaded before it is played.
// Depends on lts_pkg, lts_ctrl, lts_datapath and assert_macros.svh.
`include "assert_macros.svh"

module looping_tone_sequencer_top import lts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   lts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_word  (rsp_word)
   );

   // busy right after an accepted word
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a sounding tone implies the sequence is running
   `ASSERT_IMPLIES(a_tone_needs_play, clock, reset, rsp_valid && rsp_word.tone_on, rsp_word.is_playing)
   // a new result word only comes out of an item in work
   `ASSERT_IMPLIES(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

### tb/sv/testbench.sv
// Self-checking bench for looping_tone_sequencer_top: a directed script, then random
// play sessions; each result word checked against a scripted value or the bench model.
// Depends on lts_pkg and the RTL of the tone sequencer.
`timescale 1ns / 100ps

module testbench;
   import lts_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 160;
   localparam int SQUEEZE_LEN  = 300;
   localparam int SETTLE       = 30;

   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_word_type          word;
      bit                    typed;
      rsp_word_type          want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // sequencer model state
   logic [PITCH_W-1:0] pitch_mem [MAX_NOTES];
   logic [LEN_W-1:0]   len_mem [MAX_NOTES];
   logic [TICK_W-1:0]  position = '0;
   logic [TICK_W-1:0]  elapsed = '0;
   logic [TICK_W-1:0]  loop_len = '0;
   bit                 playing = 1'b0;
   bit                 voiced = 1'b0;
   logic [PITCH_W-1:0] pitch_now = '0;
   logic [4:0]         cfg_count = '0;
   logic [TICK_W-1:0]  cfg_duration = '0;
   int unsigned        run_count = 0;
   logic [TICK_W-1:0]  run_duration = '0;

   rsp_word_type   tones_due [$];
   script_row_type script [$];

   int  mismatch_count = 0;
   int  results_seen = 0;
   int  items_sent = 0;
   int  starts_taken = 0;
   int  starts_refused = 0;
   int  auto_stops = 0;
   int  cycle_count = 0;
   int  squeeze_left = 0;
   bit  squeeze_due = 1'b0;
   bit  squeeze_done = 1'b0;
   bit  steady = 1'b0;

   looping_tone_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: timeout after %0d cycles", cycle_count);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Advances the sequencer model by one word and returns the result it gives.
   function automatic rsp_word_type sequence_step(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  note_end;
      logic [31:0]  total;
      bit           hit;
      bit           refused;
      refused = 1'b0;
      case (w.kind)
         KIND_TICK: begin
            if (playing) begin
               note_end = '0;
               hit = 1'b0;
               // first active note whose running end reaches the loop position
               for (int n = 0; n < run_count && n < MAX_NOTES && !hit; n++) begin
                  note_end += len_mem[n];
                  if (position <= note_end) begin
                     hit = 1'b1;
                     voiced = (pitch_mem[n] != '0);
                     if (voiced) pitch_now = pitch_mem[n];
                  end
               end
               position = position + 1'b1;
               elapsed = elapsed + 1'b1;
               if (position >= loop_len) position = '0;
               if (elapsed >= run_duration) begin
                  playing = 1'b0;
                  voiced = 1'b0;
                  auto_stops++;
               end
            end
         end
         KIND_LOAD: begin
            pitch_mem[w.note_index] = w.note_pitch;
            len_mem[w.note_index] = w.note_length;
         end
         KIND_START: begin
            if (cfg_duration > MAX_PLAY_TICKS || playing) begin
               refused = 1'b1;
               starts_refused++;
            end else begin
               run_count = (cfg_count > MAX_NOTES) ? MAX_NOTES : cfg_count;
               run_duration = cfg_duration;
               total = '0;
               for (int n = 0; n < run_count; n++) begin
                  total += len_mem[n];
                  if (total > 32'hFFFFF) total = 32'hFFFFF;
               end
               loop_len = total[TICK_W-1:0];
               position = '0;
               elapsed = '0;
               playing = 1'b1;
               starts_taken++;
            end
         end
         default: begin
            if (playing) begin
               playing = 1'b0;
               voiced = 1'b0;
            end
         end
      endcase
      r.tone_on = voiced;
      r.tone_pitch = voiced ? pitch_now : '0;
      r.is_playing = playing;
      r.status = refused;
      return r;
   endfunction

   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type want);
      rsp_word_type predicted;
      if (!steady && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 21);
      end
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predicted = sequence_step(w);
      tones_due.push_back(typed ? want : predicted);
   endtask

   // Register writes wait until every expected word is back and the block is quiet.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (tones_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_index <= index;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      if (index == CSR_NOTE_COUNT) cfg_count = value[4:0];
      else if (index == CSR_PLAY_DURATION) cfg_duration = value[TICK_W-1:0];
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_tone(input rsp_word_type got);
      rsp_word_type want;
      results_seen++;
      if (tones_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: word %0d arrived with nothing expected (on=%0b pitch=%0d)",
                     results_seen, got.tone_on, got.tone_pitch);
      end else begin
         want = tones_due.pop_front();
         if (got.tone_on !== want.tone_on || got.tone_pitch !== want.tone_pitch ||
             got.is_playing !== want.is_playing || got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: word %0d expected on=%0b pitch=%0d play=%0b st=%0b, %s%0b %0d %0b %0b",
                        results_seen, want.tone_on, want.tone_pitch, want.is_playing,
                        want.status, "got ", got.tone_on, got.tone_pitch, got.is_playing,
                        got.status);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_tone(rsp_word);
         if (squeeze_due && !squeeze_done) begin
            squeeze_left = SQUEEZE_LEN;
            squeeze_done = 1'b1;
         end
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 21);
         end
      end
   end

   function automatic script_row_type step_row(input logic [KIND_W-1:0] kind,
                                               input logic [3:0] idx,
                                               input logic [PITCH_W-1:0] pitch,
                                               input logic [LEN_W-1:0] len);
      script_row_type row;
      row = '{default: '0};
      row.word = '{kind: kind, note_index: idx, note_pitch: pitch, note_length: len};
      return row;
   endfunction

   function automatic script_row_type step_row_want(input logic [KIND_W-1:0] kind,
                                                    input logic [3:0] idx,
                                                    input logic [PITCH_W-1:0] pitch,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic on, input logic [15:0] tone,
                                                    input logic play, input logic st);
      script_row_type row;
      row = step_row(kind, idx, pitch, len);
      row.typed = 1'b1;
      row.want = '{tone_on: on, tone_pitch: tone, is_playing: play, status: st};
      return row;
   endfunction

   function automatic script_row_type reg_row(input logic [CSR_IDX_W-1:0] index,
                                              input logic [CSR_DATA_W-1:0] value);
      script_row_type row;
      row = '{default: '0};
      row.is_reg = 1'b1;
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   function automatic logic [PITCH_W-1:0] pick_pitch();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r == 2) return 16'hFFFF;
      return PITCH_W'($urandom_range(1, 65535));
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      if ($urandom_range(0, 11) == 0) return LEN_W'($urandom_range(0, 65535));
      return LEN_W'($urandom_range(0, 6));
   endfunction

   // Mostly ticks while a melody plays; starts dominate while stopped.
   function automatic req_word_type random_word();
      req_word_type w;
      int p;
      w.note_index = 4'($urandom_range(0, 15));
      w.note_pitch = PITCH_W'($urandom_range(0, 65535));
      w.note_length = LEN_W'($urandom_range(0, 65535));
      p = $urandom_range(0, 99);
      if (playing)
         w.kind = (p < 78) ? KIND_TICK : (p < 88) ? KIND_LOAD : (p < 93) ? KIND_START : KIND_STOP;
      else
         w.kind = (p < 35) ? KIND_START : (p < 60) ? KIND_LOAD : (p < 85) ? KIND_TICK : KIND_STOP;
      if (w.kind == KIND_LOAD) begin
         w.note_pitch = pick_pitch();
         w.note_length = pick_length();
      end
      return w;
   endfunction

   initial begin
      req_word_type w;
      logic [4:0]   count_pick;
      logic [19:0]  dur_pick;
      int           r;

      // slots 0..3 and 15 are loaded here; note counts stay at or below four
      script.push_back(step_row_want(KIND_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_STOP, 4'd15, 16'hFFFF, 16'hFFFF,
                                     1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_START, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0));
      // zero play duration: one tick, then stopped
      script.push_back(step_row_want(KIND_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_LOAD, 4'd0, 16'd440, 16'd2, 1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_LOAD, 4'd1, 16'd0, 16'd1, 1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_LOAD, 4'd2, 16'hFFFF, 16'd0,
                                     1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_LOAD, 4'd3, 16'd1, 16'hFFFF,
                                     1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(step_row_want(KIND_LOAD, 4'd15, 16'hAAAA, 16'h5555,
                                     1'b0, 16'd0, 1'b0, 1'b0));
      script.push_back(reg_row(CSR_NOTE_COUNT, 20'd4));
      script.push_back(reg_row(CSR_PLAY_DURATION, 20'd6));
      script.push_back(step_row_want(KIND_START, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0));
      // start while running is refused
      script.push_back(step_row_want(KIND_START, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b1));
      repeat (6) script.push_back(step_row(KIND_TICK, 4'd0, 16'd0, 16'd0));
      script.push_back(reg_row(CSR_PLAY_DURATION, 20'd600001));
      script.push_back(step_row_want(KIND_START, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1));
      script.push_back(reg_row(CSR_PLAY_DURATION, 20'hFFFFF));
      script.push_back(step_row_want(KIND_START, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1));
      script.push_back(reg_row(CSR_PLAY_DURATION, 20'd600000));
      script.push_back(step_row_want(KIND_START, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0));
      script.push_back(step_row(KIND_TICK, 4'd0, 16'd0, 16'd0));
      // reload a playing note: its new pitch shows on the next tick
      script.push_back(step_row(KIND_LOAD, 4'd0, 16'd1234, 16'd3));
      script.push_back(step_row(KIND_TICK, 4'd0, 16'd0, 16'd0));
      script.push_back(step_row_want(KIND_STOP, 4'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_reg) write_reg(script[i].reg_index, script[i].reg_value);
         else send_word(script[i].word, script[i].typed, script[i].want);
      end

      // fill the whole note table so any note count is legal from here on
      for (int s = 0; s < MAX_NOTES; s++) begin
         w = '{kind: KIND_LOAD, note_index: s[3:0], note_pitch: pick_pitch(),
               note_length: pick_length()};
         send_word(w, 1'b0, '0);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         r = $urandom_range(0, 5);
         count_pick = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 : (r == 2) ? 5'd31 :
                      5'($urandom_range(1, 20));
         r = $urandom_range(0, 9);
         dur_pick = (r == 0) ? 20'd0 : (r == 1) ? 20'd600000 :
                    (r == 2) ? 20'($urandom_range(600001, 1048575)) :
                    20'($urandom_range(1, 300));
         if (phase == 0) begin
            count_pick = 5'd31;
            dur_pick = 20'd50;
         end
         write_reg(CSR_NOTE_COUNT, {15'd0, count_pick});
         write_reg(CSR_PLAY_DURATION, dur_pick);
         steady = (phase == 5);
         if (phase == 2) squeeze_due = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) send_word(random_word(), 1'b0, '0);
         if (playing) begin
            w = '{kind: KIND_STOP, note_index: '0, note_pitch: '0, note_length: '0};
            send_word(w, 1'b0, '0);
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (tones_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("testbench: %0d words sent, %0d result words checked, %0d mismatches",
               items_sent, results_seen, mismatch_count);
      $display("testbench: %0d starts taken, %0d refused, %0d runs ended by duration",
               starts_taken, starts_refused, auto_stops);
      if (mismatch_count == 0 && tones_due.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
